// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, switched off while reset is asserted.
`define PSD_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Concurrent check that also holds during reset.
`define PSD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/psd_pkg.sv =====
// Widths, types and helpers for the point to segment distance pipeline.
package psd_pkg;

    localparam int COORD_BITS   = 16;
    localparam int DIFF_BITS    = COORD_BITS + 1;
    localparam int PROD_BITS    = 2 * DIFF_BITS;
    localparam int SUM_BITS     = PROD_BITS + 2;
    localparam int MAG_BITS     = 2 * COORD_BITS + 2;
    localparam int HALF_BITS    = MAG_BITS / 2;
    localparam int DIST_BITS    = 36;
    localparam int WIDE_BITS    = (MAG_BITS > DIST_BITS) ? MAG_BITS : DIST_BITS;
    localparam int FRONT_STAGES = 4;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef logic signed [SUM_BITS-1:0]   sum_t;
    typedef logic [MAG_BITS-1:0]          mag_t;
    typedef logic [DIST_BITS-1:0]         dist_t;

    typedef enum logic [1:0] {
        REGION_START    = 2'd0,
        REGION_END      = 2'd1,
        REGION_INTERIOR = 2'd2
    } region_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    // Front end result: projection terms and the candidate distance.
    typedef struct packed {
        mag_t    e;
        mag_t    f;
        mag_t    base;
        region_t region;
    } sel_t;

    // Divider request: e*e over f.
    typedef struct packed {
        logic [2*MAG_BITS-1:0] num;
        mag_t                  f;
        mag_t                  base;
        region_t               region;
    } quot_req_t;

    typedef struct packed {
        mag_t    quot;
        mag_t    base;
        region_t region;
    } quot_t;

    function automatic dist_t sat_dist(input mag_t v);
        logic [WIDE_BITS-1:0] w;
        logic [WIDE_BITS-1:0] lim;
        w   = WIDE_BITS'(v);
        lim = WIDE_BITS'({DIST_BITS{1'b1}});
        return (w > lim) ? {DIST_BITS{1'b1}} : w[DIST_BITS-1:0];
    endfunction

endpackage

// ===== rtl/point_segment_distance_squared_core.sv =====
// Top level: squared distance from a point to a 3D segment, fully pipelined.
//
// Input channel: in_valid / in_stall carry one request of nine signed
// coordinates (segment start a, segment end b, query point c).
// Output channel: out_valid / out_stall carry dist_sq and region
// (0 nearest start, 1 nearest end, 2 interior projection).
// The pipeline has four front-end stages (differences, products,
// dot sums, region select), two squaring stages, one divider stage per
// quotient bit (34) and the output register.
// Throughput is one request per cycle while the receiver does not stall; every stage holds its own valid bit.
// When the receiver stalls, the output register holds its result and the
// stages behind it keep filling, so bubbles close up; in_stall rises only
// once every stage holds a request.
// Reset clears all valid bits; the pipeline comes up empty and ready.
module point_segment_distance_squared_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [psd_pkg::COORD_BITS-1:0] ax,
    input  logic signed [psd_pkg::COORD_BITS-1:0] ay,
    input  logic signed [psd_pkg::COORD_BITS-1:0] az,
    input  logic signed [psd_pkg::COORD_BITS-1:0] bx,
    input  logic signed [psd_pkg::COORD_BITS-1:0] by,
    input  logic signed [psd_pkg::COORD_BITS-1:0] bz,
    input  logic signed [psd_pkg::COORD_BITS-1:0] cx,
    input  logic signed [psd_pkg::COORD_BITS-1:0] cy,
    input  logic signed [psd_pkg::COORD_BITS-1:0] cz,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [psd_pkg::DIST_BITS-1:0]         dist_sq,
    output logic [1:0]                            region
);

    psd_pkg::point_t    pt_a;
    psd_pkg::point_t    pt_b;
    psd_pkg::point_t    pt_c;

    logic               front_ready;
    logic               front_valid;
    psd_pkg::sel_t      front_data;
    logic               sq_ready;
    logic               sq_valid;
    psd_pkg::quot_req_t sq_data;
    logic               div_ready;
    logic               div_valid;
    psd_pkg::quot_t     div_data;
    logic               out_ready;

    logic               out_valid_reg;
    psd_pkg::dist_t     dist_reg;
    psd_pkg::dist_t     dist_next;
    psd_pkg::region_t   region_reg;
    psd_pkg::mag_t      diff_mag;

    assign pt_a = '{x: ax, y: ay, z: az};
    assign pt_b = '{x: bx, y: by, z: bz};
    assign pt_c = '{x: cx, y: cy, z: cz};

    psd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (front_ready),
        .a         (pt_a),
        .b         (pt_b),
        .c         (pt_c),
        .out_valid (front_valid),
        .out_ready (sq_ready),
        .out_data  (front_data)
    );

    psd_square u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (sq_ready),
        .in_data   (front_data),
        .out_valid (sq_valid),
        .out_ready (div_ready),
        .out_data  (sq_data)
    );

    psd_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_ready  (div_ready),
        .in_data   (sq_data),
        .out_valid (div_valid),
        .out_ready (out_ready),
        .out_data  (div_data)
    );

    assign in_stall  = !front_ready;
    assign out_ready = !out_valid_reg || !out_stall;

    // The truncated quotient never exceeds |AC|^2 in the interior case.
    always_comb
    begin
        if (div_data.region == psd_pkg::REGION_INTERIOR)
        begin
            diff_mag = div_data.base - div_data.quot;
        end
        else
        begin
            diff_mag = div_data.base;
        end
        dist_next = psd_pkg::sat_dist(diff_mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready)
        begin
            dist_reg   <= dist_next;
            region_reg <= div_data.region;
        end
    end

    assign out_valid = out_valid_reg;
    assign dist_sq   = dist_reg;
    assign region    = region_reg;

endmodule

// ===== rtl/psd_front.sv =====
// Front end: differences, products, dot sums and region select, four stages.
module psd_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  psd_pkg::point_t  a,
    input  psd_pkg::point_t  b,
    input  psd_pkg::point_t  c,
    output logic             out_valid,
    input  logic             out_ready,
    output psd_pkg::sel_t    out_data
);

    logic                    valid_reg [psd_pkg::FRONT_STAGES];
    logic                    ready     [psd_pkg::FRONT_STAGES];

    psd_pkg::diff_t ab_reg [3];
    psd_pkg::diff_t ac_reg [3];
    psd_pkg::diff_t bc_reg [3];

    psd_pkg::prod_t eab_reg  [3];
    psd_pkg::prod_t fab_reg  [3];
    psd_pkg::prod_t acsq_reg [3];
    psd_pkg::prod_t bcsq_reg [3];

    psd_pkg::sum_t  e_reg;
    psd_pkg::sum_t  f_reg;
    psd_pkg::sum_t  acs_reg;
    psd_pkg::sum_t  bcs_reg;

    psd_pkg::sel_t  sel_reg;
    psd_pkg::sel_t  sel_next;

    // A stage takes new data when empty or when its successor moves on.
    assign ready[3] = !valid_reg[3] || out_ready;
    assign ready[2] = !valid_reg[2] || ready[3];
    assign ready[1] = !valid_reg[1] || ready[2];
    assign ready[0] = !valid_reg[0] || ready[1];

    assign in_ready  = ready[0];
    assign out_valid = valid_reg[3];
    assign out_data  = sel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < psd_pkg::FRONT_STAGES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (ready[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < psd_pkg::FRONT_STAGES; i++)
            begin
                if (ready[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            ab_reg[0] <= psd_pkg::DIFF_BITS'(b.x) - psd_pkg::DIFF_BITS'(a.x);
            ab_reg[1] <= psd_pkg::DIFF_BITS'(b.y) - psd_pkg::DIFF_BITS'(a.y);
            ab_reg[2] <= psd_pkg::DIFF_BITS'(b.z) - psd_pkg::DIFF_BITS'(a.z);
            ac_reg[0] <= psd_pkg::DIFF_BITS'(c.x) - psd_pkg::DIFF_BITS'(a.x);
            ac_reg[1] <= psd_pkg::DIFF_BITS'(c.y) - psd_pkg::DIFF_BITS'(a.y);
            ac_reg[2] <= psd_pkg::DIFF_BITS'(c.z) - psd_pkg::DIFF_BITS'(a.z);
            bc_reg[0] <= psd_pkg::DIFF_BITS'(c.x) - psd_pkg::DIFF_BITS'(b.x);
            bc_reg[1] <= psd_pkg::DIFF_BITS'(c.y) - psd_pkg::DIFF_BITS'(b.y);
            bc_reg[2] <= psd_pkg::DIFF_BITS'(c.z) - psd_pkg::DIFF_BITS'(b.z);
        end
        if (ready[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                eab_reg[i]  <= psd_pkg::PROD_BITS'(ac_reg[i]) *
                               psd_pkg::PROD_BITS'(ab_reg[i]);
                fab_reg[i]  <= psd_pkg::PROD_BITS'(ab_reg[i]) *
                               psd_pkg::PROD_BITS'(ab_reg[i]);
                acsq_reg[i] <= psd_pkg::PROD_BITS'(ac_reg[i]) *
                               psd_pkg::PROD_BITS'(ac_reg[i]);
                bcsq_reg[i] <= psd_pkg::PROD_BITS'(bc_reg[i]) *
                               psd_pkg::PROD_BITS'(bc_reg[i]);
            end
        end
        if (ready[2])
        begin
            e_reg   <= psd_pkg::SUM_BITS'(eab_reg[0]) + psd_pkg::SUM_BITS'(eab_reg[1])
                     + psd_pkg::SUM_BITS'(eab_reg[2]);
            f_reg   <= psd_pkg::SUM_BITS'(fab_reg[0]) + psd_pkg::SUM_BITS'(fab_reg[1])
                     + psd_pkg::SUM_BITS'(fab_reg[2]);
            acs_reg <= psd_pkg::SUM_BITS'(acsq_reg[0]) + psd_pkg::SUM_BITS'(acsq_reg[1])
                     + psd_pkg::SUM_BITS'(acsq_reg[2]);
            bcs_reg <= psd_pkg::SUM_BITS'(bcsq_reg[0]) + psd_pkg::SUM_BITS'(bcsq_reg[1])
                     + psd_pkg::SUM_BITS'(bcsq_reg[2]);
        end
        if (ready[3])
        begin
            sel_reg <= sel_next;
        end
    end

    // f, |AC|^2 and |BC|^2 are never negative; e only matters when positive.
    always_comb
    begin
        sel_next.e = e_reg[psd_pkg::MAG_BITS-1:0];
        sel_next.f = f_reg[psd_pkg::MAG_BITS-1:0];
        if (e_reg[psd_pkg::SUM_BITS-1] || (e_reg == '0))
        begin
            sel_next.region = psd_pkg::REGION_START;
            sel_next.base   = acs_reg[psd_pkg::MAG_BITS-1:0];
        end
        else if (e_reg >= f_reg)
        begin
            sel_next.region = psd_pkg::REGION_END;
            sel_next.base   = bcs_reg[psd_pkg::MAG_BITS-1:0];
        end
        else
        begin
            sel_next.region = psd_pkg::REGION_INTERIOR;
            sel_next.base   = acs_reg[psd_pkg::MAG_BITS-1:0];
        end
    end

endmodule

// ===== rtl/psd_square.sv =====
// Squares e from half-width partial products over two stages.
module psd_square (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  psd_pkg::sel_t      in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output psd_pkg::quot_req_t out_data
);

    localparam int NUM_BITS = 2 * psd_pkg::MAG_BITS;

    logic                        valid0_reg;
    logic                        valid1_reg;
    logic                        ready0;
    logic                        ready1;
    logic [psd_pkg::HALF_BITS-1:0] e_hi;
    logic [psd_pkg::HALF_BITS-1:0] e_lo;

    psd_pkg::mag_t     p_hh_reg;
    psd_pkg::mag_t     p_hl_reg;
    psd_pkg::mag_t     p_ll_reg;
    psd_pkg::mag_t     f_reg;
    psd_pkg::mag_t     base_reg;
    psd_pkg::region_t  region_reg;
    psd_pkg::quot_req_t req_reg;
    psd_pkg::quot_req_t req_next;

    assign e_hi = in_data.e[psd_pkg::MAG_BITS-1:psd_pkg::HALF_BITS];
    assign e_lo = in_data.e[psd_pkg::HALF_BITS-1:0];

    assign ready1    = !valid1_reg || out_ready;
    assign ready0    = !valid0_reg || ready1;
    assign in_ready  = ready0;
    assign out_valid = valid1_reg;
    assign out_data  = req_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg <= 1'b0;
            valid1_reg <= 1'b0;
        end
        else
        begin
            if (ready0)
            begin
                valid0_reg <= in_valid;
            end
            if (ready1)
            begin
                valid1_reg <= valid0_reg;
            end
        end
    end

    // e*e = hh << MAG + 2*hl << HALF + ll
    always_comb
    begin
        req_next.num    = (NUM_BITS'(p_hh_reg) << psd_pkg::MAG_BITS)
                        + (NUM_BITS'(p_hl_reg) << (psd_pkg::HALF_BITS + 1))
                        + NUM_BITS'(p_ll_reg);
        req_next.f      = f_reg;
        req_next.base   = base_reg;
        req_next.region = region_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ready0)
        begin
            p_hh_reg   <= psd_pkg::MAG_BITS'(e_hi) * psd_pkg::MAG_BITS'(e_hi);
            p_hl_reg   <= psd_pkg::MAG_BITS'(e_hi) * psd_pkg::MAG_BITS'(e_lo);
            p_ll_reg   <= psd_pkg::MAG_BITS'(e_lo) * psd_pkg::MAG_BITS'(e_lo);
            f_reg      <= in_data.f;
            base_reg   <= in_data.base;
            region_reg <= in_data.region;
        end
        if (ready1)
        begin
            req_reg <= req_next;
        end
    end

endmodule

// ===== rtl/psd_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module psd_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  psd_pkg::quot_req_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output psd_pkg::quot_t     out_data
);

    localparam int M = psd_pkg::MAG_BITS;

    typedef struct packed {
        psd_pkg::mag_t    rem;
        psd_pkg::mag_t    f;
        psd_pkg::mag_t    low;
        psd_pkg::mag_t    quot;
        psd_pkg::mag_t    base;
        psd_pkg::region_t region;
    } step_t;

    step_t stage_reg [M];
    logic  valid_reg [M];
    logic  ready     [M];

    // Interior items have e < f, so the quotient fits M bits and the top
    // half of e*e is already below f.
    genvar k;
    for (k = 0; k < M; k++)
    begin : g_step
        step_t      step_in;
        step_t      step_next;
        logic       valid_in;
        logic       ready_down;
        logic [M:0] trial;
        logic       fits;

        if (k == 0)
        begin : g_first
            assign step_in = '{rem:    in_data.num[2*M-1:M],
                               f:      in_data.f,
                               low:    in_data.num[M-1:0],
                               quot:   '0,
                               base:   in_data.base,
                               region: in_data.region};
            assign valid_in = in_valid;
        end
        else
        begin : g_rest
            assign step_in  = stage_reg[k-1];
            assign valid_in = valid_reg[k-1];
        end

        if (k == M - 1)
        begin : g_last
            assign ready_down = out_ready;
        end
        else
        begin : g_mid
            assign ready_down = ready[k+1];
        end

        assign ready[k] = !valid_reg[k] || ready_down;

        always_comb
        begin
            trial     = {step_in.rem, step_in.low[M-1]};
            fits      = (trial >= {1'b0, step_in.f});
            step_next = step_in;
            step_next.low  = {step_in.low[M-2:0], 1'b0};
            step_next.quot = {step_in.quot[M-2:0], fits};
            if (fits)
            begin
                step_next.rem = M'(trial - {1'b0, step_in.f});
            end
            else
            begin
                step_next.rem = trial[M-1:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (ready[k])
            begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ready[k])
            begin
                stage_reg[k] <= step_next;
            end
        end
    end

    assign in_ready  = ready[0];
    assign out_valid = valid_reg[M-1];
    assign out_data  = '{quot:   stage_reg[M-1].quot,
                         base:   stage_reg[M-1].base,
                         region: stage_reg[M-1].region};

endmodule

// ===== rtl/psd_checker.sv =====
// Port-level checks for the distance core, bound to the top level.
`include "assert_macros.svh"

module psd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [psd_pkg::DIST_BITS-1:0] dist_sq,
    input logic [1:0]                    region
);

    // Valid is cleared asynchronously by reset; the check samples it at the next edge.
    `PSD_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "output valid after reset")

    `PSD_ASSERT_RST(a_stall_full, clk, rst_n, in_stall |-> out_valid && out_stall, "input stalled with room in the pipeline")

    `PSD_ASSERT_RST(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(dist_sq) && $stable(region), "stalled result changed")

endmodule

bind point_segment_distance_squared_core psd_checker u_psd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dist_sq   (dist_sq),
    .region    (region)
);

// ===== sim/point_segment_distance_squared_core_tb.sv =====
// Self-checking testbench for the point to segment squared distance core.
`timescale 1ns / 1ps

module point_segment_distance_squared_core_tb;

    typedef struct {
        psd_pkg::dist_t   dist_sq;
        psd_pkg::region_t region;
    } dist_result_t;

    localparam logic [63:0] DIST_LIMIT = (64'd1 << psd_pkg::DIST_BITS) - 64'd1;
    localparam int EXTREMES [7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    psd_pkg::coord_t ax = '0, ay = '0, az = '0;
    psd_pkg::coord_t bx = '0, by = '0, bz = '0;
    psd_pkg::coord_t cx = '0, cy = '0, cz = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [psd_pkg::DIST_BITS-1:0] dist_sq;
    logic [1:0] region;

    dist_result_t pending_distances [$];
    int error_count = 0;
    int requests_sent = 0;
    int results_seen = 0;
    int region_seen [3] = '{0, 0, 0};
    int stall_left = 0;
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;

    point_segment_distance_squared_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .ax        (ax),
        .ay        (ay),
        .az        (az),
        .bx        (bx),
        .by        (by),
        .bz        (bz),
        .cx        (cx),
        .cy        (cy),
        .cz        (cz),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dist_sq   (dist_sq),
        .region    (region)
    );

    always #1 clk = ~clk;

    // Squared distance from c to segment ab, exact products, truncated quotient.
    function automatic dist_result_t predict_distance(psd_pkg::point_t a, psd_pkg::point_t b,
                                                      psd_pkg::point_t c);
        longint pa [3];
        longint pb [3];
        longint pc [3];
        longint ab, ac, bc;
        longint e, f, acsq, bcsq;
        logic [127:0] num;
        logic [127:0] quot;
        logic [63:0] dist_wide;
        dist_result_t r;
        pa[0] = $signed(a.x); pa[1] = $signed(a.y); pa[2] = $signed(a.z);
        pb[0] = $signed(b.x); pb[1] = $signed(b.y); pb[2] = $signed(b.z);
        pc[0] = $signed(c.x); pc[1] = $signed(c.y); pc[2] = $signed(c.z);
        e = 0;
        f = 0;
        acsq = 0;
        bcsq = 0;
        for (int i = 0; i < 3; i++)
        begin
            ab = pb[i] - pa[i];
            ac = pc[i] - pa[i];
            bc = pc[i] - pb[i];
            e += ac * ab;
            f += ab * ab;
            acsq += ac * ac;
            bcsq += bc * bc;
        end
        if (e <= 0)
        begin
            dist_wide = acsq;
            r.region = psd_pkg::REGION_START;
        end
        else if (e >= f)
        begin
            dist_wide = bcsq;
            r.region = psd_pkg::REGION_END;
        end
        else
        begin
            num = {64'd0, e} * {64'd0, e};
            quot = num / {64'd0, f};
            dist_wide = acsq - quot[63:0];
            r.region = psd_pkg::REGION_INTERIOR;
        end
        if (dist_wide > DIST_LIMIT)
            dist_wide = DIST_LIMIT;
        r.dist_sq = dist_wide[psd_pkg::DIST_BITS-1:0];
        return r;
    endfunction

    function automatic psd_pkg::point_t pt(int x, int y, int z);
        psd_pkg::point_t p;
        p.x = psd_pkg::coord_t'(x);
        p.y = psd_pkg::coord_t'(y);
        p.z = psd_pkg::coord_t'(z);
        return p;
    endfunction

    function automatic psd_pkg::point_t rand_point();
        return pt($urandom, $urandom, $urandom);
    endfunction

    function automatic psd_pkg::point_t extreme_point();
        return pt(EXTREMES[$urandom_range(0, 6)], EXTREMES[$urandom_range(0, 6)],
                  EXTREMES[$urandom_range(0, 6)]);
    endfunction

    // Point scattered within +-128 of a centre well inside the coordinate range.
    function automatic psd_pkg::point_t near_point(int mx, int my, int mz);
        return pt(mx + int'($urandom_range(0, 255)) - 128,
                  my + int'($urandom_range(0, 255)) - 128,
                  mz + int'($urandom_range(0, 255)) - 128);
    endfunction

    task automatic send_request(psd_pkg::point_t a, psd_pkg::point_t b, psd_pkg::point_t c);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, 5) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        ax <= a.x; ay <= a.y; az <= a.z;
        bx <= b.x; by <= b.y; bz <= b.z;
        cx <= c.x; cy <= c.y; cz <= c.z;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_distances.push_back(predict_distance(a, b, c));
        requests_sent++;
    endtask

    task automatic send_random_request();
        psd_pkg::point_t a, b, c;
        int mx, my, mz, k;
        a = rand_point();
        b = rand_point();
        c = rand_point();
        case ($urandom_range(0, 9))
            4, 5:
            begin
                // short segment with a nearby point: small dot products
                mx = int'($urandom_range(0, 64000)) - 32000;
                my = int'($urandom_range(0, 64000)) - 32000;
                mz = int'($urandom_range(0, 64000)) - 32000;
                a = near_point(mx, my, mz);
                b = near_point(mx, my, mz);
                c = near_point(mx, my, mz);
            end
            6:
                b = a;
            7:
            begin
                // point at or beside the segment (coordinates rounded), ends included
                k = $urandom_range(0, 8);
                c = pt(int'(a.x) + (int'(b.x) - int'(a.x)) * k / 8,
                       int'(a.y) + (int'(b.y) - int'(a.y)) * k / 8,
                       int'(a.z) + (int'(b.z) - int'(a.z)) * k / 8);
            end
            8:
            begin
                a = extreme_point();
                b = extreme_point();
                c = extreme_point();
            end
            default: ;
        endcase
        send_request(a, b, c);
    endtask

    task automatic wait_until_empty();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_distances.size() != 0);
    endtask

    task automatic test_corner_cases();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        send_request(pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0));
        // degenerate segments
        send_request(pt(100, -200, 300), pt(100, -200, 300), pt(-5, 7, 9));
        send_request(pt(-32768, -32768, -32768), pt(-32768, -32768, -32768),
                     pt(32767, 32767, 32767));
        send_request(pt(32767, 32767, 32767), pt(32767, 32767, 32767),
                     pt(-32768, -32768, -32768));
        // longest segment, point at either end, beside it and at the origin
        send_request(pt(-32768, -32768, -32768), pt(32767, 32767, 32767),
                     pt(32767, 32767, 32767));
        send_request(pt(-32768, -32768, -32768), pt(32767, 32767, 32767),
                     pt(-32768, -32768, -32768));
        send_request(pt(-32768, -32768, -32768), pt(32767, 32767, 32767),
                     pt(32767, -32768, -32768));
        send_request(pt(32767, 32767, 32767), pt(-32768, -32768, -32768), pt(0, 0, 0));
        send_request(pt(-32768, -32768, -32768), pt(32767, 32767, 32767), pt(0, 0, 0));
        // projection exactly at each end, and just past it
        send_request(pt(0, 0, 0), pt(10, 0, 0), pt(10, 7, 0));
        send_request(pt(0, 0, 0), pt(10, 0, 0), pt(0, 5, 3));
        send_request(pt(0, 0, 0), pt(10, 0, 0), pt(-1, 5, 0));
        send_request(pt(0, 0, 0), pt(10, 0, 0), pt(11, -5, 2));
        // interior projections, with and without quotient truncation; c equal to a
        send_request(pt(0, 0, 0), pt(1, 1, 0), pt(1, 0, 0));
        send_request(pt(0, 0, 0), pt(3, 1, 0), pt(1, 2, 0));
        send_request(pt(-1, -1, -1), pt(1, 1, 1), pt(1, -1, 1));
        send_request(pt(32767, -32768, 0), pt(-32768, 32767, 0), pt(0, 0, 32767));
        send_request(pt(-32768, 0, 0), pt(32767, 0, 0), pt(0, 32767, -32768));
        send_request(pt(1234, -4321, 77), pt(-900, 2500, 31000), pt(1234, -4321, 77));
        send_request(pt(21845, -21846, 21845), pt(-21846, 21845, -21846),
                     pt(-1, 0, 32767));
        send_request(pt(-21846, 21845, -21846), pt(21845, -21846, 21845),
                     pt(-32768, -1, 0));
    endtask

    task automatic test_back_to_back();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (200) send_random_request();
    endtask

    // receiver stalls while the sender never idles, so the pipe fills
    task automatic test_output_backpressure();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b1;
        repeat (250) send_random_request();
    endtask

    task automatic test_sparse_input();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b0;
        repeat (200) send_random_request();
    endtask

    task automatic test_pause_until_empty();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (50) send_random_request();
        wait_until_empty();
        repeat (50) send_random_request();
    endtask

    task automatic test_random_mix();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (700) send_random_request();
    endtask

    always @(posedge clk)
    begin : check_results
        dist_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_distances.size() == 0)
                begin
                    $display("%0t: unexpected result: dist_sq %0d region %0d",
                             $time, dist_sq, region);
                    error_count++;
                end
                else
                begin
                    want = pending_distances.pop_front();
                    if (dist_sq !== want.dist_sq)
                    begin
                        $display("%0t: dist_sq mismatch: expected %0d, actual %0d",
                                 $time, want.dist_sq, dist_sq);
                        error_count++;
                    end
                    if (region !== want.region)
                    begin
                        $display("%0t: region mismatch: expected %0d, actual %0d",
                                 $time, want.region, region);
                        error_count++;
                    end
                end
                results_seen++;
                if (region < 2'd3)
                    region_seen[region]++;
                stall_left = rx_idle_en ? $urandom_range(0, 5) : 0;
                out_stall <= (stall_left != 0);
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                out_stall <= (stall_left != 0);
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corner_cases();
        test_back_to_back();
        test_output_backpressure();
        test_sparse_input();
        test_pause_until_empty();
        test_random_mix();
        wait_until_empty();
        // catch any stray result
        repeat (60) @(posedge clk);
        $display("Summary: %0d requests, %0d results (start %0d, end %0d, interior %0d)",
                 requests_sent, results_seen, region_seen[0], region_seen[1],
                 region_seen[2]);
        $display("Summary: %0d mismatches, %0d results still outstanding",
                 error_count, pending_distances.size());
        if (error_count == 0 && pending_distances.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #400000;
        $display("Timeout with %0d results outstanding", pending_distances.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/psd_pkg.sv
rtl/psd_front.sv
rtl/psd_square.sv
rtl/psd_divider.sv
rtl/point_segment_distance_squared_core.sv
rtl/psd_checker.sv
sim/point_segment_distance_squared_core_tb.sv
